[src/bmp_24bit_to_rgba_stream_decoder_assert.svh]
// Assertion macros for the BMP stream decoder.
// BMP_ASSERT_SAME checks the consequent on the same edge.
// BMP_ASSERT_NEXT checks the consequent on the following edge.
`ifndef BMP_24BIT_TO_RGBA_STREAM_DECODER_ASSERT_SVH
`define BMP_24BIT_TO_RGBA_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTH
`define BMP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bmp decoder check failed");
`define BMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bmp decoder check failed");
`else
`define BMP_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define BMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/bmp_dec_pkg.sv]
package bmp_dec_pkg;

  localparam int unsigned MAX_WIDTH  = 8192;
  localparam int unsigned MAX_HEIGHT = 8192;

  localparam int DIM_W   = 14;  // image size fields
  localparam int COORD_W = 13;  // column / row fields
  localparam int TDATA_W = 96;  // result tdata, padded to bytes

  // header byte positions (last byte of each field)
  localparam logic [31:0] POS_SIG_B      = 32'd0;
  localparam logic [31:0] POS_SIG_M      = 32'd1;
  localparam logic [31:0] POS_OFFSET     = 32'd13;
  localparam logic [31:0] POS_HDR_SIZE   = 32'd17;
  localparam logic [31:0] POS_WIDTH      = 32'd21;
  localparam logic [31:0] POS_HEIGHT     = 32'd25;
  localparam logic [31:0] POS_DEPTH      = 32'd29;
  localparam logic [31:0] POS_COMPRESS   = 32'd33;
  localparam logic [31:0] POS_HDR_END    = 32'd53;

  localparam logic [7:0]  SIG_B          = 8'h42;
  localparam logic [7:0]  SIG_M          = 8'h4D;
  localparam logic [31:0] INFO_HDR_SIZE  = 32'd40;
  localparam logic [31:0] MIN_OFFSET     = 32'd54;
  localparam logic [15:0] PALETTE_DEPTH  = 16'd16;
  localparam logic [15:0] PIXEL_DEPTH    = 16'd24;
  localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SIGNATURE   = 3'd1,
    ERR_HDR_SIZE    = 3'd2,
    ERR_COMPRESSION = 3'd3,
    ERR_NO_PALETTE  = 3'd4,
    ERR_DEPTH       = 3'd5,
    ERR_TRUNCATED   = 3'd6,
    ERR_DIMENSION   = 3'd7
  } err_code_t;

endpackage

[src/bmp_24bit_to_rgba_stream_decoder.sv]
// Channel  | Dir | tdata (low bit up)                          | tlast        | tuser
// ---------+-----+---------------------------------------------+--------------+--------------
// in_      | in  | data_byte[7:0]                              | end_of_file  | start_of_file
// out_     | out | red, green, blue, alpha, column, row,       | end_of_image | kind
//          |     | error_code, image_width, image_height, pad  |              | (1 = error)
//
// One byte per cycle while in_tready is high: each byte is decoded from the
// state registers straight into the result register, one transaction per clock.
// Header, skip and pixel counters all advance on the input transaction itself.
// A held result stalls input only when out_tready is low with a result pending.
// rst_n is synchronous; the first byte after reset is file byte 0.
// start_of_file restarts decoding on that byte; after the final pixel or an
// error all bytes are dropped until the next start_of_file.

`include "bmp_24bit_to_rgba_stream_decoder_assert.svh"

module bmp_24bit_to_rgba_stream_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // end_of_file
  input  logic                              in_tuser,   // start_of_file
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [44:32] column,
  // [57:45] row, [60:58] error_code, [74:61] image_width,
  // [88:75] image_height, [95:89] zero
  output logic [bmp_dec_pkg::TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,  // end_of_image
  output logic                              out_tuser   // kind: 0 pixel, 1 error
);

  import bmp_dec_pkg::*;

  // decoder state
  phase_t              phase_r,  phase_nxt;
  logic [31:0]         pos_r,    pos_nxt;
  logic [31:0]         shift_r,  shift_nxt;
  logic [31:0]         offset_r, offset_nxt;
  logic [DIM_W-1:0]    width_r,  width_nxt;
  logic [DIM_W-1:0]    height_r, height_nxt;
  logic [15:0]         depth_r,  depth_nxt;
  logic [COORD_W-1:0]  col_r,    col_nxt;
  logic [COORD_W-1:0]  row_r,    row_nxt;
  logic [14:0]         rbc_r,    rbc_nxt;
  logic [15:0]         pbytes_r, pbytes_nxt;
  logic [1:0]          tri_r,    tri_nxt;

  // state as seen by this byte (start_of_file restarts it)
  phase_t              phase_cur;
  logic [31:0]         pos_cur;
  logic [31:0]         shift_cur;
  logic [COORD_W-1:0]  col_cur;
  logic [COORD_W-1:0]  row_cur;
  logic [14:0]         rbc_cur;
  logic [1:0]          tri_cur;

  // result register
  logic                out_valid_r;
  logic                out_kind_r;
  logic                out_last_r;
  logic [TDATA_W-1:0]  out_data_r;

  logic                in_fire;
  logic                sof_fire;
  logic [31:0]         shift_new;
  logic [31:0]         w_abs;
  logic [15:0]         row_pix_bytes;
  logic [15:0]         row_size;
  logic [15:0]         rbc_inc;
  err_code_t           err_code;
  logic                pix;
  logic                last;
  logic [7:0]          px_red;
  logic [7:0]          px_green;
  logic [7:0]          px_blue;
  logic                res_valid;
  logic [TDATA_W-1:0]  res_data;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign sof_fire  = in_fire && in_tuser;

  assign phase_cur = sof_fire ? PH_HEADER : phase_r;
  assign pos_cur   = sof_fire ? '0 : pos_r;
  assign shift_cur = sof_fire ? '0 : shift_r;
  assign col_cur   = sof_fire ? '0 : col_r;
  assign row_cur   = sof_fire ? '0 : row_r;
  assign rbc_cur   = sof_fire ? '0 : rbc_r;
  assign tri_cur   = sof_fire ? '0 : tri_r;

  // little-endian header fields shift in from the top
  assign shift_new = {in_tdata, shift_cur[31:8]};
  assign w_abs     = shift_new[31] ? (~shift_new + 32'd1) : shift_new;

  // bytes of pixel data per row, and the row size padded to 4 bytes
  assign row_pix_bytes = {2'b00, width_r} + {1'b0, width_r, 1'b0};
  assign row_size      = (row_pix_bytes + 16'd3) & ~16'd3;
  assign rbc_inc       = {1'b0, rbc_cur} + 16'd1;

  always_comb begin
    phase_nxt  = phase_cur;
    pos_nxt    = pos_cur;
    shift_nxt  = shift_cur;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    col_nxt    = col_cur;
    row_nxt    = row_cur;
    rbc_nxt    = rbc_cur;
    pbytes_nxt = pbytes_r;
    tri_nxt    = tri_cur;
    err_code   = ERR_NONE;
    pix        = 1'b0;
    last       = 1'b0;
    px_red     = '0;
    px_green   = '0;
    px_blue    = '0;

    if (in_fire) begin
      case (phase_cur)
        PH_HEADER: begin
          shift_nxt = shift_new;
          pos_nxt   = pos_cur + 32'd1;
          if (pos_cur == POS_SIG_B && in_tdata != SIG_B) begin
            err_code = ERR_SIGNATURE;
          end else if (pos_cur == POS_SIG_M && in_tdata != SIG_M) begin
            err_code = ERR_SIGNATURE;
          end else if (pos_cur == POS_OFFSET) begin
            offset_nxt = shift_new;
          end else if (pos_cur == POS_HDR_SIZE && shift_new != INFO_HDR_SIZE) begin
            err_code = ERR_HDR_SIZE;
          end else if (pos_cur == POS_WIDTH) begin
            // sign only marks a mirrored image; magnitude is the width
            if (w_abs == 32'd0 || w_abs > 32'(MAX_WIDTH)) begin
              err_code = ERR_DIMENSION;
            end else begin
              width_nxt = w_abs[DIM_W-1:0];
            end
          end else if (pos_cur == POS_HEIGHT) begin
            if (shift_new[31] || shift_new == 32'd0 || shift_new > 32'(MAX_HEIGHT)) begin
              err_code = ERR_DIMENSION;
            end else begin
              height_nxt = shift_new[DIM_W-1:0];
            end
          end else if (pos_cur == POS_DEPTH) begin
            depth_nxt = shift_new[31:16];
          end else if (pos_cur == POS_COMPRESS && shift_new != 32'd0) begin
            err_code = ERR_COMPRESSION;
          end else if (pos_cur == POS_HDR_END) begin
            if (offset_r < MIN_OFFSET) begin
              err_code = ERR_DIMENSION;
            end else if (offset_r == MIN_OFFSET && depth_r <= PALETTE_DEPTH) begin
              err_code = ERR_NO_PALETTE;
            end else if (depth_r != PIXEL_DEPTH) begin
              err_code = ERR_DEPTH;
            end else begin
              phase_nxt = (({1'b0, pos_cur} + 33'd1) >= {1'b0, offset_r}) ?
                          PH_DATA : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          // palette and gap bytes are dropped unread
          phase_nxt = (({1'b0, pos_cur} + 33'd1) >= {1'b0, offset_r}) ?
                      PH_DATA : PH_SKIP;
          pos_nxt   = pos_cur + 32'd1;
        end
        PH_DATA: begin
          if ({1'b0, rbc_cur} < row_pix_bytes) begin
            case (tri_cur)
              2'd0: begin
                pbytes_nxt = {8'h00, in_tdata};
                tri_nxt    = 2'd1;
              end
              2'd1: begin
                pbytes_nxt = {in_tdata, pbytes_r[7:0]};
                tri_nxt    = 2'd2;
              end
              default: begin
                px_blue  = pbytes_r[7:0];
                px_green = pbytes_r[15:8];
                px_red   = in_tdata;
                pix      = 1'b1;
                last     = (({1'b0, row_cur} + 14'd1) == height_r) &&
                           (({1'b0, col_cur} + 14'd1) == width_r);
                col_nxt  = col_cur + 13'd1;
                tri_nxt  = 2'd0;
              end
            endcase
          end
          if (rbc_inc >= row_size) begin
            // end of row including padding
            rbc_nxt = '0;
            col_nxt = '0;
            tri_nxt = 2'd0;
            row_nxt = row_cur + 13'd1;
          end else begin
            rbc_nxt = rbc_inc[14:0];
          end
          if (last) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          // image finished: bytes are dropped until start_of_file
        end
      endcase

      // end of file before the final pixel; header faults win
      if (phase_cur != PH_DONE && err_code == ERR_NONE && in_tlast && !last) begin
        err_code = ERR_TRUNCATED;
      end
      if (err_code != ERR_NONE) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  assign res_valid = in_fire && (err_code != ERR_NONE || pix);

  always_comb begin
    res_data = '0;
    if (err_code != ERR_NONE) begin
      res_data[60:58] = err_code;
    end else begin
      res_data[7:0]   = px_red;
      res_data[15:8]  = px_green;
      res_data[23:16] = px_blue;
      res_data[31:24] = ALPHA_OPAQUE;
      res_data[44:32] = col_cur;
      res_data[57:45] = row_cur;
      res_data[74:61] = width_r;
      res_data[88:75] = height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      shift_r  <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      depth_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      rbc_r    <= '0;
      pbytes_r <= '0;
      tri_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rbc_r    <= rbc_nxt;
      pbytes_r <= pbytes_nxt;
      tri_r    <= tri_nxt;
    end
  end

  // result register: valid is refilled whenever a byte is taken, else cleared when out_tready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind_r <= (err_code != ERR_NONE);
      out_last_r <= last && (err_code == ERR_NONE);
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

  // an error result carries nothing but its code
  `BMP_ASSERT_SAME(a_err_clean, clk, rst_n, out_tvalid && out_tuser, out_tdata[57:0] == 58'd0 && out_tdata[95:61] == 35'd0 && !out_tlast)
  // a pixel result is opaque and carries no error code
  `BMP_ASSERT_SAME(a_pix_clean, clk, rst_n, out_tvalid && !out_tuser, out_tdata[31:24] == ALPHA_OPAQUE && out_tdata[60:58] == 3'd0)
  // a finished image produces nothing until restarted
  `BMP_ASSERT_SAME(a_done_quiet, clk, rst_n, in_fire && !in_tuser && phase_r == PH_DONE, !res_valid)
  // any error closes the image
  `BMP_ASSERT_NEXT(a_err_done, clk, rst_n, in_fire && err_code != ERR_NONE, phase_r == PH_DONE)

endmodule

[verif/bmp_rgba_checker_pkg.sv]
package bmp_rgba_checker_pkg;
  import bmp_dec_pkg::*;

  // one result transaction, split into its fields
  typedef struct {
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] column;
    logic [12:0] row;
    logic        eoi;
    err_code_t   code;
    logic [13:0] img_w;
    logic [13:0] img_h;
    logic [6:0]  pad;
  } rgba_result_t;

  class rgba_stream_checker;
    rgba_result_t decoded_q[$];
    int unsigned  bad_results;

    // decoder state
    phase_t       ph;
    logic [31:0]  pos;
    logic [31:0]  hdr_shift;
    logic [31:0]  data_off;
    logic [15:0]  depth;
    logic [15:0]  pix_bytes;
    int unsigned  img_w;
    int unsigned  img_h;
    int unsigned  col;
    int unsigned  row;
    int unsigned  row_bytes;
    int unsigned  triplet_pos;

    function new();
      bad_results = 0;
      restart();
    endfunction

    function void restart();
      ph          = PH_HEADER;
      pos         = '0;
      hdr_shift   = '0;
      data_off    = '0;
      depth       = '0;
      pix_bytes   = '0;
      img_w       = 0;
      img_h       = 0;
      col         = 0;
      row         = 0;
      row_bytes   = 0;
      triplet_pos = 0;
    endfunction

    // Advances the decoder by one accepted byte; returns 0 if it was dropped.
    function bit decode_byte(input logic [7:0] b, input logic eof, input logic sof);
      err_code_t    code;
      bit           pix;
      bit           last;
      logic [31:0]  mag;
      int unsigned  row_pix;
      int unsigned  row_size;
      rgba_result_t r;
      code = ERR_NONE;
      pix  = 1'b0;
      last = 1'b0;
      if (sof) restart();
      if (ph == PH_DONE) return 1'b0;

      if (ph == PH_HEADER) begin
        hdr_shift = {b, hdr_shift[31:8]};
        case (pos)
          POS_SIG_B: if (b != SIG_B) code = ERR_SIGNATURE;
          POS_SIG_M: if (b != SIG_M) code = ERR_SIGNATURE;
          POS_OFFSET: data_off = hdr_shift;
          POS_HDR_SIZE: if (hdr_shift != INFO_HDR_SIZE) code = ERR_HDR_SIZE;
          POS_WIDTH: begin
            mag = hdr_shift[31] ? 32'd0 - hdr_shift : hdr_shift;
            if (mag == 0 || mag > MAX_WIDTH) code = ERR_DIMENSION;
            else img_w = mag;
          end
          POS_HEIGHT: begin
            if (hdr_shift[31] || hdr_shift == 0 || hdr_shift > MAX_HEIGHT) begin
              code = ERR_DIMENSION;
            end else begin
              img_h = hdr_shift;
            end
          end
          POS_DEPTH: depth = hdr_shift[31:16];
          POS_COMPRESS: if (hdr_shift != 0) code = ERR_COMPRESSION;
          POS_HDR_END: begin
            if (data_off < MIN_OFFSET) code = ERR_DIMENSION;
            else if (data_off == MIN_OFFSET && depth <= PALETTE_DEPTH) code = ERR_NO_PALETTE;
            else if (depth != PIXEL_DEPTH) code = ERR_DEPTH;
            else ph = ({1'b0, pos} + 33'd1 >= {1'b0, data_off}) ? PH_DATA : PH_SKIP;
          end
          default: ;
        endcase
        pos = pos + 1;
      end else if (ph == PH_SKIP) begin
        ph  = ({1'b0, pos} + 33'd1 >= {1'b0, data_off}) ? PH_DATA : PH_SKIP;
        pos = pos + 1;
      end else begin
        row_pix  = 3 * img_w;
        row_size = ((24 * img_w + 31) / 32) * 4;
        if (row_bytes < row_pix) begin
          if (triplet_pos == 0) begin
            pix_bytes   = {8'h00, b};
            triplet_pos = 1;
          end else if (triplet_pos == 1) begin
            pix_bytes[15:8] = b;
            triplet_pos     = 2;
          end else begin
            last        = (row + 1 == img_h) && (col + 1 == img_w);
            pix         = 1'b1;
            r.kind      = 1'b0;
            r.blue      = pix_bytes[7:0];
            r.green     = pix_bytes[15:8];
            r.red       = b;
            r.alpha     = ALPHA_OPAQUE;
            r.column    = 13'(col);
            r.row       = 13'(row);
            r.eoi       = last;
            r.img_w     = 14'(img_w);
            r.img_h     = 14'(img_h);
            col         = col + 1;
            triplet_pos = 0;
          end
        end
        row_bytes = row_bytes + 1;
        if (row_bytes >= row_size) begin
          row_bytes   = 0;
          col         = 0;
          triplet_pos = 0;
          row         = row + 1;
        end
        if (last) ph = PH_DONE;
      end

      // eof before the final pixel; a header fault on the same byte wins
      if (code == ERR_NONE && eof && !last) code = ERR_TRUNCATED;
      if (code != ERR_NONE) begin
        ph       = PH_DONE;
        r.kind   = 1'b1;
        r.red    = '0;
        r.green  = '0;
        r.blue   = '0;
        r.alpha  = '0;
        r.column = '0;
        r.row    = '0;
        r.eoi    = 1'b0;
        r.img_w  = '0;
        r.img_h  = '0;
      end
      r.code = code;
      r.pad  = '0;
      if (pix || code != ERR_NONE) decoded_q.push_back(r);
      return 1'b1;
    endfunction

    function void compare_output(input logic [TDATA_W-1:0] d, input logic eoi,
                                 input logic kind);
      rgba_result_t got;
      rgba_result_t want;
      got.kind   = kind;
      got.red    = d[7:0];
      got.green  = d[15:8];
      got.blue   = d[23:16];
      got.alpha  = d[31:24];
      got.column = d[44:32];
      got.row    = d[57:45];
      got.eoi    = eoi;
      got.code   = err_code_t'(d[60:58]);
      got.img_w  = d[74:61];
      got.img_h  = d[88:75];
      got.pad    = d[95:89];
      if (decoded_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("unexpected output: kind=%0d err=%0d col=%0d row=%0d",
                   got.kind, got.code, got.column, got.row);
        end
        return;
      end
      want = decoded_q.pop_front();
      if (got.kind !== want.kind || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha !== want.alpha ||
          got.column !== want.column || got.row !== want.row || got.eoi !== want.eoi ||
          got.code !== want.code || got.img_w !== want.img_w ||
          got.img_h !== want.img_h || got.pad !== want.pad) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("output mismatch, want: kind=%0d bgr=%h/%h/%h a=%h col=%0d row=%0d",
                   want.kind, want.blue, want.green, want.red, want.alpha,
                   want.column, want.row, " eoi=%0d err=%0d size=%0dx%0d",
                   want.eoi, want.code, want.img_w, want.img_h);
          $display("                   got: kind=%0d bgr=%h/%h/%h a=%h col=%0d row=%0d",
                   got.kind, got.blue, got.green, got.red, got.alpha,
                   got.column, got.row, " eoi=%0d err=%0d size=%0dx%0d pad=%h",
                   got.eoi, got.code, got.img_w, got.img_h, got.pad);
        end
      end
    endfunction
  endclass

endpackage

[verif/tb.sv]
// Testbench for the 24-bit BMP to RGBA stream decoder.
// BMP files are built byte by byte and streamed in; a checker object
// decodes the same bytes and compares every output transaction.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmp_dec_pkg::*;
  import bmp_rgba_checker_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 4000;  // idle cycles before giving up
  localparam int unsigned RANDOM_BYTES = 250;   // decoded bytes in the random part
  localparam int unsigned TAIL_CYCLES  = 16;

  // recipe for one file on the wire
  typedef struct {
    logic [7:0]  sig_b;
    logic [7:0]  sig_m;
    logic [31:0] offset;
    logic [31:0] hdr_size;
    logic [31:0] width_f;
    logic [31:0] height_f;
    logic [31:0] compression;
    logic [15:0] depth;
    int          cut;         // index of the last byte sent, -1 sends it all
    bit          eof_at_end;  // mark the last byte sent with eof
    bit          with_sof;
    bit          trim_pad;    // file stops on the final pixel byte
    int unsigned junk;        // stray bytes after the file
  } bmp_file_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] data_byte
  logic                in_tlast;   // end_of_file
  logic                in_tuser;   // start_of_file
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;  // red, green, blue, alpha, column, row,
                                   // error_code, image_width, image_height, pad
  logic                out_tlast;  // end_of_image
  logic                out_tuser;  // kind

  rgba_stream_checker  sb;
  int unsigned         live_bytes   = 0;  // bytes the decoder did not drop
  int unsigned         quiet_cycles = 0;
  int unsigned         hold_cycles  = 0;
  bit                  in_calm      = 1'b0;
  bit                  out_calm     = 1'b0;

  bmp_24bit_to_rgba_stream_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic bmp_file_t good_file(input int unsigned w, input int unsigned h,
                                          input int unsigned pal);
    bmp_file_t f;
    f.sig_b       = SIG_B;
    f.sig_m       = SIG_M;
    f.offset      = MIN_OFFSET + pal;
    f.hdr_size    = INFO_HDR_SIZE;
    f.width_f     = w;
    f.height_f    = h;
    f.compression = '0;
    f.depth       = PIXEL_DEPTH;
    f.cut         = -1;
    f.eof_at_end  = 1'b1;
    f.with_sof    = 1'b1;
    f.trim_pad    = 1'b0;
    f.junk        = 0;
    return f;
  endfunction

  // Entered and left at a falling edge. tvalid stays high across
  // back-to-back transactions and drops only for a gap.
  task automatic send_byte(input logic [7:0] b, input logic eof, input logic sof);
    int unsigned gap;
    gap = (in_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_file(input bmp_file_t f);
    logic [7:0]  img[$];
    logic [31:0] mag;
    int unsigned row_size;
    int unsigned body;
    int unsigned pal_len;
    int          n;
    // header with random filler, then the fields the decoder looks at
    repeat (54) img.push_back(8'($urandom));
    img[0] = f.sig_b;
    img[1] = f.sig_m;
    for (int i = 0; i < 4; i++) begin
      img[10 + i] = f.offset[8*i +: 8];
      img[14 + i] = f.hdr_size[8*i +: 8];
      img[18 + i] = f.width_f[8*i +: 8];
      img[22 + i] = f.height_f[8*i +: 8];
      img[30 + i] = f.compression[8*i +: 8];
    end
    img[28] = f.depth[7:0];
    img[29] = f.depth[15:8];

    // palette up to the data offset; an absurd offset gets a few bytes only
    if (f.offset > 54 && f.offset <= 1078) pal_len = f.offset - 54;
    else if (f.offset > 1078) pal_len = 8;
    else pal_len = 0;
    repeat (pal_len) img.push_back(8'($urandom));

    mag = f.width_f[31] ? 32'd0 - f.width_f : f.width_f;
    if (mag != 0 && mag <= MAX_WIDTH && !f.height_f[31] && f.height_f != 0 &&
        f.height_f <= MAX_HEIGHT) begin
      row_size = ((24 * mag + 31) / 32) * 4;
      body     = row_size * f.height_f;
      if (f.trim_pad) body = body - (row_size - 3 * mag);
    end else begin
      body = $urandom_range(0, 12);
    end
    repeat (body) img.push_back(8'($urandom));

    n = (f.cut >= 0 && f.cut < img.size()) ? f.cut + 1 : img.size();
    for (int i = 0; i < n; i++) begin
      send_byte(img[i], f.eof_at_end && (i == n - 1), f.with_sof && (i == 0));
    end
    repeat (f.junk) send_byte(8'($urandom), 1'($urandom), 1'b0);
  endtask

  // Result side backpressure: now and then ready drops for a pause drawn from idle_len().
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles--;
    end else if (!out_calm && $urandom_range(0, 99) < 20) begin
      hold_cycles = idle_len();
    end
    out_tready <= (hold_cycles == 0);
    if ($urandom_range(0, 299) == 0) begin
      out_calm = !out_calm;
    end
  end

  // Both channels are sampled on the rising edge; inputs first, so a
  // prediction is always queued before its output can be compared.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (sb.decode_byte(in_tdata, in_tlast, in_tuser)) live_bytes++;
      end
      if (out_tvalid && out_tready) begin
        sb.compare_output(out_tdata, out_tlast, out_tuser);
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    bmp_file_t   f;
    int unsigned random_start;
    int unsigned pick;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    in_tuser  <= 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed files ----
    // first file after reset carries no start mark
    f = good_file(1, 1, 0);
    f.with_sof = 1'b0;
    send_file(f);
    // sign of the width dropped, palette skipped, no trailing pad, junk ignored
    f = good_file(3, 2, 4);
    f.width_f  = 32'd0 - f.width_f;
    f.trim_pad = 1'b1;
    f.junk     = 4;
    send_file(f);
    // signature faults
    f = good_file(1, 1, 0);
    f.sig_b = 8'h00;
    f.junk  = 2;
    send_file(f);
    f = good_file(1, 1, 0);
    f.sig_m = 8'hFF;
    send_file(f);
    // info header size other than 40
    f = good_file(1, 1, 0);
    f.hdr_size = 32'd12;
    send_file(f);
    // width zero, just over the max, and negative over the max
    f = good_file(1, 1, 0);
    f.width_f = 32'd0;
    send_file(f);
    f = good_file(1, 1, 0);
    f.width_f = MAX_WIDTH + 1;
    send_file(f);
    f = good_file(1, 1, 0);
    f.width_f = 32'hFFFF_DFFF;
    send_file(f);
    // height negative, zero, over the max
    f = good_file(1, 1, 0);
    f.height_f = 32'hFFFF_FFFF;
    send_file(f);
    f = good_file(1, 1, 0);
    f.height_f = 32'd0;
    send_file(f);
    f = good_file(1, 1, 0);
    f.height_f = MAX_HEIGHT + 1;
    send_file(f);
    // compressed
    f = good_file(1, 1, 0);
    f.compression = 32'hFFFF_FFFF;
    send_file(f);
    // data offset inside the header
    f = good_file(1, 1, 0);
    f.offset = MIN_OFFSET - 1;
    send_file(f);
    // paletted depths with no palette
    f = good_file(1, 1, 0);
    f.depth = 16'd8;
    send_file(f);
    f = good_file(1, 1, 0);
    f.depth = PALETTE_DEPTH;
    send_file(f);
    // paletted depth with a palette, and a 32-bit depth: both unsupported
    f = good_file(2, 1, 1024);
    f.depth = 16'd8;
    f.cut   = 60;
    send_file(f);
    f = good_file(2, 1, 4);
    f.depth = 16'd32;
    send_file(f);
    // truncation in the header, in the skip region, on a completed pixel
    f = good_file(2, 2, 0);
    f.cut = 20;
    send_file(f);
    f = good_file(2, 2, 0);
    f.offset = 32'hFFFF_FFFF;
    send_file(f);
    f = good_file(3, 2, 0);
    f.cut = 56;
    send_file(f);
    // header fault and eof on the same byte: the header fault is reported
    f = good_file(1, 1, 0);
    f.hdr_size = 32'd0;
    f.cut      = 17;
    send_file(f);
    // file abandoned mid-image, then restarted by the next start mark
    f = good_file(4, 3, 0);
    f.cut        = 70;
    f.eof_at_end = 1'b1;
    f.eof_at_end = 1'b0;
    send_file(f);
    send_file(good_file(2, 2, 0));
    // widest row (negative width) and tallest column, broken off early
    f = good_file(MAX_WIDTH, 1, 0);
    f.width_f = 32'd0 - f.width_f;
    f.cut     = 69;
    send_file(f);
    f = good_file(1, MAX_HEIGHT, 0);
    f.trim_pad = 1'b1;
    f.cut      = 77;
    send_file(f);

    // ---- random files: mostly well formed, some faulty or broken off ----
    random_start = live_bytes;
    while (live_bytes - random_start < RANDOM_BYTES) begin
      in_calm = ($urandom_range(0, 4) == 0);
      f = good_file($urandom_range(1, 6), $urandom_range(1, 4),
                    ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0);
      if ($urandom_range(0, 3) == 0) f.width_f = 32'd0 - f.width_f;
      f.trim_pad = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) f.junk = $urandom_range(1, 8);
      pick = $urandom_range(0, 29);
      case (pick)
        18: begin
          f.sig_b = 8'($urandom);
          if (f.sig_b == SIG_B) f.sig_b = ~SIG_B;
        end
        19: begin
          f.sig_m = 8'($urandom);
          if (f.sig_m == SIG_M) f.sig_m = ~SIG_M;
        end
        20: f.hdr_size = INFO_HDR_SIZE ^ (32'd1 << $urandom_range(0, 31));
        21: f.width_f = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        22: f.height_f = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        23: f.compression = 32'd1 << $urandom_range(0, 31);
        24: f.offset = $urandom_range(0, MIN_OFFSET - 1);
        25: f.depth = 16'($urandom);
        26: f.cut = $urandom_range(0, 80);
        27: begin
          f.cut        = $urandom_range(0, 80);
          f.eof_at_end = 1'b0;
        end
        28: f.with_sof = 1'b0;
        29: f.junk = $urandom_range(1, 8);
        default: ;
      endcase
      send_file(f);
    end
    in_tvalid <= 1'b0;

    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.bad_results == 0 && sb.decoded_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bmp_dec_pkg.sv
src/bmp_24bit_to_rgba_stream_decoder.sv
verif/bmp_rgba_checker_pkg.sv
verif/tb.sv
